FILE: rtl/dwr_pkg.sv
// ----------------------------------------------------------------------------
// dwr_pkg
// Shared types and constants of the draw-without-replacement block.
// ----------------------------------------------------------------------------
package dwr_pkg;

   localparam int WORD_W     = 31;   // random word
   localparam int CNT_W      = 11;   // pool count, pool_size, left_count
   localparam int RANGE_W    = 15;   // range_start
   localparam int VALUE_W    = 16;   // drawn_value
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 15;
   localparam int DIV_STEP_W = $clog2(WORD_W + 1);

   localparam logic [CNT_W-1:0] POOL_SIZE_RESET = 11'd1024;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_START = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_SIZE   = 1'b1;

   // request kinds
   localparam logic REQ_DRAW    = 1'b0;
   localparam logic REQ_RESTART = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_DIVIDE,
      ST_SELECT,
      ST_SHIFT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;    // reload own position
      logic shift;   // take neighbor value if at or above the draw index
   } cell_ctrl_type;

endpackage

FILE: rtl/dwr_if.sv
// ----------------------------------------------------------------------------
// dwr request / response channels
// Valid/ready channels carrying the request and response beats.
// ----------------------------------------------------------------------------
interface dwr_req_if import dwr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [WORD_W-1:0] random_word;

   modport source (output valid, output req_type, output random_word, input ready);
   modport sink   (input valid, input req_type, input random_word, output ready);
endinterface

interface dwr_rsp_if import dwr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] drawn_value;
   logic               pool_empty;
   logic [CNT_W-1:0]   left_count;

   modport source (output valid, output drawn_value, output pool_empty,
                   output left_count, input ready);
   modport sink   (input valid, input drawn_value, input pool_empty,
                   input left_count, output ready);
endinterface

FILE: rtl/dwr_div.sv
// ----------------------------------------------------------------------------
// dwr_div
// Restoring remainder unit: one quotient bit per cycle over the random word.
// ----------------------------------------------------------------------------
module dwr_div import dwr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WORD_W-1:0] dividend,
   input  logic [CNT_W-1:0]  divisor,
   output logic             done,
   output logic [CNT_W-1:0]  remainder
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [WORD_W-1:0]     quo_ff, quo_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]      div_ff, div_in;
   logic [CNT_W:0]        shifted;
   logic [CNT_W:0]        diff;

   assign shifted = {rem_ff, quo_ff[WORD_W-1]};
   assign diff    = shifted - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = DIV_STEP_W'(WORD_W);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the result fits CNT_W bits
         rem_in  = (shifted >= {1'b0, div_ff}) ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
         quo_in  = {quo_ff[WORD_W-2:0], 1'b0};
         step_in = step_ff - 1'b1;
         if (step_ff == DIV_STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: rtl/dwr_cell.sv
// ----------------------------------------------------------------------------
// dwr_cell
// One pool slot: holds an offset, reloads its position, or closes the gap.
// ----------------------------------------------------------------------------
module dwr_cell import dwr_pkg::*; #(
   parameter int IDX_W = 10,
   parameter int POS   = 0
) (
   input  logic             clock,
   input  cell_ctrl_type    ctrl,
   input  logic [IDX_W-1:0] idx,
   input  logic [IDX_W-1:0] next_value,
   output logic [IDX_W-1:0] value
);

   localparam logic [IDX_W-1:0] MY_POS = IDX_W'(POS);

   logic [IDX_W-1:0] value_ff, value_in;

   always_comb begin
      value_in = value_ff;
      if (ctrl.load) begin
         value_in = MY_POS;
      end else if (ctrl.shift && (MY_POS >= idx)) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

FILE: rtl/dwr_sel.sv
// ----------------------------------------------------------------------------
// dwr_sel
// Registered mux tree picking the cell at the draw index, one level a cycle.
// ----------------------------------------------------------------------------
module dwr_sel import dwr_pkg::*; #(
   parameter int DEPTH = 1024,
   parameter int IDX_W = 10
) (
   input  logic             clock,
   input  logic [IDX_W-1:0] leaf [DEPTH],
   input  logic [IDX_W-1:0] idx,
   output logic [IDX_W-1:0] root
);

   localparam int P2 = 1 << IDX_W;

   logic [IDX_W-1:0] leaf_pad [P2];
   logic [IDX_W-1:0] node_ff  [1:P2-1];
   logic [IDX_W-1:0] node_in  [1:P2-1];

   for (genvar j = 0; j < P2; j++) begin : g_pad
      if (j < DEPTH) begin : g_real
         assign leaf_pad[j] = leaf[j];
      end else begin : g_fill
         assign leaf_pad[j] = '0;
      end
   end

   // node k sits at level floor(log2 k); the root uses the top index bit
   for (genvar k = 1; k < P2; k++) begin : g_node
      localparam int LVL = $clog2(k + 1) - 1;
      if (2 * k >= P2) begin : g_bottom
         assign node_in[k] = idx[IDX_W-1-LVL] ? leaf_pad[2*k+1-P2] : leaf_pad[2*k-P2];
      end else begin : g_inner
         assign node_in[k] = idx[IDX_W-1-LVL] ? node_ff[2*k+1] : node_ff[2*k];
      end
   end

   always_ff @(posedge clock) begin
      node_ff <= node_in;
   end

   assign root = node_ff[1];

endmodule

FILE: rtl/draw_without_replacement_top.sv
// ----------------------------------------------------------------------------
// draw_without_replacement_top
// Ordered pool of range_start .. range_start+min(pool_size, POOL_DEPTH)-1,
// drawn at random without replacement.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries a request beat: req_type restart refills the pool in order,
//   req_type draw takes random_word mod (entries left) as an index, returns
//   the value there and removes it; the rest keep their order. Each request
//   gives exactly one rsp_ch beat (drawn_value, pool_empty, left_count).
//   csr_* writes range_start (index 0) and pool_size (index 1); write only
//   while the block is idle.
// Sequence (accept to rsp_ch.valid high):
//   restart: ST_FILL reloads the cells, then ST_DONE. Empty draw: ST_DONE.
//   draw: ST_DIVIDE, ST_SELECT, ST_SHIFT, then ST_DONE, paced by the
//   31-step remainder unit and the registered select tree over the cells.
//   One request is in flight at a time; a new request is taken only
//   after the previous response has been loaded into the output register.
// Reset: pool empty, range_start 0, pool_size 1024. When rsp_ch stalls the
//   response holds and the block waits with req_ch.ready low after one
//   further request has finished.
// ----------------------------------------------------------------------------
module draw_without_replacement_top import dwr_pkg::*; #(
   parameter int POOL_DEPTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   dwr_req_if.sink               req_ch,
   dwr_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W     = $clog2(POOL_DEPTH);
   localparam int SEL_CNT_W = $clog2(IDX_W + 1);

   state_type              state_ff, state_in;
   logic [RANGE_W-1:0]     range_start_ff;
   logic [CNT_W-1:0]       pool_size_ff;
   logic [CNT_W-1:0]       remaining_ff, remaining_in;
   logic [VALUE_W-1:0]     drawn_ff, drawn_in;
   logic                   empty_ff, empty_in;
   logic [SEL_CNT_W-1:0]   sel_cnt_ff, sel_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]     rsp_drawn_ff;
   logic                   rsp_empty_ff;
   logic [CNT_W-1:0]       rsp_left_ff;

   logic                   req_accept;
   logic                   rsp_free;
   logic                   rsp_load;
   logic                   div_start;
   logic                   div_done;
   logic [CNT_W-1:0]       div_rem;
   logic [IDX_W-1:0]       draw_idx;
   logic [CNT_W-1:0]       fill_count;
   logic [IDX_W-1:0]       sel_root;
   cell_ctrl_type          cell_ctrl;
   logic [IDX_W-1:0]       cell_value [POOL_DEPTH];

   assign req_accept = req_ch.valid & req_ch.ready;
   assign rsp_free   = ~rsp_valid_ff | rsp_ch.ready;
   assign draw_idx   = IDX_W'(div_rem);
   assign fill_count = (int'(pool_size_ff) > POOL_DEPTH) ? CNT_W'(POOL_DEPTH)
                                                         : pool_size_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_ch.req_type == REQ_RESTART) begin
                  state_in = ST_FILL;
               end else if (remaining_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_FILL:   state_in = ST_DONE;
         ST_DIVIDE: begin
            if (div_done) state_in = ST_SELECT;
         end
         ST_SELECT: begin
            if (sel_cnt_ff == SEL_CNT_W'(IDX_W - 1)) state_in = ST_SHIFT;
         end
         ST_SHIFT:  state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ch.ready    = 1'b0;
      cell_ctrl.load  = 1'b0;
      cell_ctrl.shift = 1'b0;
      div_start       = 1'b0;
      rsp_load        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            div_start    = req_ch.valid && (req_ch.req_type == REQ_DRAW)
                           && (remaining_ff != '0);
         end
         ST_FILL:   cell_ctrl.load  = 1'b1;
         ST_SHIFT:  cell_ctrl.shift = 1'b1;
         ST_DONE:   rsp_load        = rsp_free;
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      remaining_in = remaining_ff;
      drawn_in     = drawn_ff;
      empty_in     = empty_ff;
      sel_cnt_in   = '0;
      if (state_ff == ST_IDLE && req_accept) begin
         drawn_in = '0;
         empty_in = (req_ch.req_type == REQ_DRAW) && (remaining_ff == '0);
      end
      if (state_ff == ST_FILL) begin
         remaining_in = fill_count;
      end
      if (state_ff == ST_SELECT) begin
         sel_cnt_in = sel_cnt_ff + 1'b1;
      end
      if (state_ff == ST_SHIFT) begin
         remaining_in = remaining_ff - 1'b1;
         drawn_in     = VALUE_W'(range_start_ff) + VALUE_W'(sel_root);
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         remaining_ff   <= '0;
         sel_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         range_start_ff <= '0;
         pool_size_ff   <= POOL_SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         remaining_ff <= remaining_in;
         sel_cnt_ff   <= sel_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_RANGE_START: range_start_ff <= csr_wdata[RANGE_W-1:0];
               CSR_POOL_SIZE:   pool_size_ff   <= csr_wdata[CNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      drawn_ff <= drawn_in;
      empty_ff <= empty_in;
      if (rsp_load) begin
         rsp_drawn_ff <= drawn_ff;
         rsp_empty_ff <= empty_ff;
         rsp_left_ff  <= remaining_ff;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.drawn_value = rsp_drawn_ff;
   assign rsp_ch.pool_empty  = rsp_empty_ff;
   assign rsp_ch.left_count  = rsp_left_ff;

   dwr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_ch.random_word),
      .divisor   (remaining_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // cells: each shifts in its upper neighbor; the last one holds
   for (genvar i = 0; i < POOL_DEPTH; i++) begin : g_cell
      logic [IDX_W-1:0] next_value;
      if (i == POOL_DEPTH - 1) begin : g_last
         assign next_value = cell_value[i];
      end else begin : g_mid
         assign next_value = cell_value[i+1];
      end
      dwr_cell #(
         .IDX_W (IDX_W),
         .POS   (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .idx        (draw_idx),
         .next_value (next_value),
         .value      (cell_value[i])
      );
   end

   dwr_sel #(
      .DEPTH (POOL_DEPTH),
      .IDX_W (IDX_W)
   ) u_sel (
      .clock (clock),
      .leaf  (cell_value),
      .idx   (draw_idx),
      .root  (sel_root)
   );

endmodule

FILE: rtl/dwr_chk.sv
// ----------------------------------------------------------------------------
// dwr_chk
// Port-level checks of the draw-without-replacement block, bound to the top.
// ----------------------------------------------------------------------------
module dwr_chk import dwr_pkg::*; #(
   parameter int POOL_DEPTH = 1024
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [VALUE_W-1:0] drawn_value,
   input logic               pool_empty,
   input logic [CNT_W-1:0]   left_count
);

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(drawn_value)
         && $stable(pool_empty) && $stable(left_count))
      else $error("response beat changed while stalled");

   // one request at a time: nothing is taken right after an accepted beat
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one in flight");

   a_empty_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && pool_empty |-> drawn_value == '0 && left_count == '0)
      else $error("empty response carries a value or a count");

   a_left_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(left_count) <= POOL_DEPTH)
      else $error("left_count above pool depth");

   // a taken draw response with a nonzero value never carries an all-ones count
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !pool_empty && drawn_value != '0 |->
         left_count != '1)
      else $error("count wrapped on a draw");

endmodule

bind draw_without_replacement_top dwr_chk #(
   .POOL_DEPTH (POOL_DEPTH)
) u_dwr_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .drawn_value (rsp_ch.drawn_value),
   .pool_empty  (rsp_ch.pool_empty),
   .left_count  (rsp_ch.left_count)
);

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks draw_without_replacement_top against a pool tracker kept in the
// bench: directed restarts and draws at the edges, then random refill/drain
// sequences with noise, under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module tb import dwr_pkg::*; ();

   localparam int POOL_DEPTH     = 1024;
   localparam int OFFSET_W       = $clog2(POOL_DEPTH);
   localparam int RANDOM_ITEMS   = 1800;
   localparam int PHASE_ITEMS    = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 60;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [VALUE_W-1:0] drawn_value;
      logic               pool_empty;
      logic [CNT_W-1:0]   left_count;
   } draw_result_type;

   class pool_scoreboard;
      logic [RANGE_W-1:0]  range_start;
      logic [CNT_W-1:0]    pool_size;
      logic [OFFSET_W-1:0] offsets[$];
      draw_result_type     expected_draws[$];
      int                  errors;

      function new();
         range_start = '0;
         pool_size   = POOL_SIZE_RESET;
         errors      = 0;
      endfunction

      function int pending();
         return expected_draws.size();
      endfunction

      // predicts the response beat of one accepted request
      function void note_request(logic kind, logic [WORD_W-1:0] word);
         draw_result_type res;
         int unsigned     fill;
         int unsigned     idx;
         res = '0;
         if (kind == REQ_RESTART) begin
            fill = (pool_size > POOL_DEPTH) ? POOL_DEPTH : pool_size;
            offsets.delete();
            for (int k = 0; k < fill; k++)
               offsets.push_back(OFFSET_W'(k));
         end else if (offsets.size() == 0) begin
            res.pool_empty = 1'b1;
         end else begin
            idx = int'(word) % offsets.size();
            res.drawn_value = VALUE_W'(range_start) + VALUE_W'(offsets[idx]);
            offsets.delete(idx);
         end
         res.left_count = CNT_W'(offsets.size());
         expected_draws.push_back(res);
      endfunction

      function void check_response(draw_result_type got);
         draw_result_type exp;
         if (expected_draws.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: unexpected beat value=%0d empty=%0d left=%0d", $realtime,
                        got.drawn_value, got.pool_empty, got.left_count);
            return;
         end
         exp = expected_draws.pop_front();
         if (got.drawn_value !== exp.drawn_value || got.pool_empty !== exp.pool_empty ||
             got.left_count !== exp.left_count) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display({"%0t: mismatch value exp %0d got %0d, empty exp %0d got %0d,",
                         " left exp %0d got %0d"},
                        $realtime, exp.drawn_value, got.drawn_value, exp.pool_empty,
                        got.pool_empty, exp.left_count, got.left_count);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dwr_req_if req_ch();
   dwr_rsp_if rsp_ch();

   pool_scoreboard sb;
   int             send_idle_pct;
   int             recv_stall_pct;
   int             sent_items;
   int             quiet_cycles;

   draw_without_replacement_top #(.POOL_DEPTH(POOL_DEPTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // response side, request monitor and watchdog
   always @(posedge clock) begin
      draw_result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.drawn_value = rsp_ch.drawn_value;
         got.pool_empty  = rsp_ch.pool_empty;
         got.left_count  = rsp_ch.left_count;
         sb.check_response(got);
      end
      if (!reset && req_ch.valid && req_ch.ready)
         sb.note_request(req_ch.req_type, req_ch.random_word);
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(9))
         0:       return WORD_W'($urandom_range(3));
         1:       return '1;
         default: return WORD_W'($urandom);
      endcase
   endfunction

   // valid stays high from one beat to the next unless a gap is taken
   task automatic send_beat(input logic kind, input logic [WORD_W-1:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.req_type    <= kind;
      req_ch.random_word <= word;
      do @(posedge clock); while (!req_ch.ready);
      sent_items++;
   endtask

   // let the monitor note the last accepted beat, then wait out every pending response
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // upper data bits above the pool_size field are junk and must be ignored
   task automatic write_config(input logic [RANGE_W-1:0] start, input logic [CNT_W-1:0] size);
      csr_we    <= 1'b1;
      csr_index <= CSR_RANGE_START;
      csr_wdata <= start;
      @(posedge clock);
      csr_index <= CSR_POOL_SIZE;
      csr_wdata <= {4'($urandom_range(15)), size};
      @(posedge clock);
      csr_we <= 1'b0;
      sb.range_start = start;
      sb.pool_size   = size;
   endtask

   initial begin
      int                 phase;
      int                 phase_start;
      int                 random_start;
      int unsigned        fill;
      int unsigned        draws;
      logic [RANGE_W-1:0] start;
      logic [CNT_W-1:0]   size;

      sb                 = new();
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.req_type    = REQ_DRAW;
      req_ch.random_word = '0;
      csr_we             = 1'b0;
      csr_index          = CSR_RANGE_START;
      csr_wdata          = '0;
      send_idle_pct      = 0;
      recv_stall_pct     = 0;
      sent_items         = 0;
      quiet_cycles       = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // draws before any restart find the pool empty
      send_beat(REQ_DRAW, '0);
      send_beat(REQ_DRAW, '1);
      send_beat(REQ_RESTART, '0);
      send_beat(REQ_DRAW, '0);
      send_beat(REQ_DRAW, '1);
      send_beat(REQ_DRAW, WORD_W'(1021));
      drain();
      write_config('1, CNT_W'(1));
      send_beat(REQ_RESTART, '1);
      send_beat(REQ_DRAW, '1);
      send_beat(REQ_DRAW, WORD_W'(5));
      drain();
      // zero pool_size: restart leaves nothing to draw
      write_config(RANGE_W'(12345), '0);
      send_beat(REQ_RESTART, '0);
      send_beat(REQ_DRAW, WORD_W'(9));
      drain();
      // oversized pool_size saturates; last entry gives the widest value
      write_config('1, '1);
      send_beat(REQ_RESTART, '0);
      send_beat(REQ_DRAW, WORD_W'(1023));
      send_beat(REQ_DRAW, WORD_W'(31'h5555_5555));
      send_beat(REQ_RESTART, WORD_W'(31'h2AAA_AAAA));
      send_beat(REQ_DRAW, WORD_W'(2047));
      drain();
      write_config('0, CNT_W'(2));
      send_beat(REQ_RESTART, '0);
      send_beat(REQ_DRAW, WORD_W'(1));
      send_beat(REQ_DRAW, '1);
      send_beat(REQ_DRAW, '0);
      drain();

      random_start = sent_items;
      phase = 0;
      while (sent_items - random_start < RANDOM_ITEMS) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
         endcase
         start = RANGE_W'($urandom);
         case ($urandom_range(19))
            0:       size = '0;
            1:       size = CNT_W'($urandom_range(1025, 2047));
            2:       size = CNT_W'($urandom_range(49, 300));
            default: size = CNT_W'($urandom_range(1, 48));
         endcase
         if (phase == 0) size = CNT_W'(POOL_DEPTH);
         if (phase == 1) begin start = '0; size = CNT_W'(1); end
         if (phase == 2) start = '1;
         write_config(start, size);
         fill = (size > POOL_DEPTH) ? POOL_DEPTH : size;

         phase_start = sent_items;
         while (sent_items - phase_start < PHASE_ITEMS &&
                sent_items - random_start < RANDOM_ITEMS) begin
            if ($urandom_range(99) < 85) begin
               // refill, then drain fully (sometimes past empty) or cut short
               send_beat(REQ_RESTART, pick_word());
               if ($urandom_range(3) == 0)
                  draws = $urandom_range(fill);
               else
                  draws = fill + $urandom_range(2);
               repeat (draws) send_beat(REQ_DRAW, pick_word());
            end else begin
               send_beat(($urandom_range(9) < 3) ? REQ_RESTART : REQ_DRAW, pick_word());
            end
         end
         drain();
         phase++;
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

FILE: sim.f
rtl/dwr_pkg.sv
rtl/dwr_if.sv
rtl/dwr_div.sv
rtl/dwr_cell.sv
rtl/dwr_sel.sv
rtl/draw_without_replacement_top.sv
rtl/dwr_chk.sv
bench/tb.sv
